// ----- src/pn3_pkg.sv -----
// types, constants and helpers for the 3d gradient noise pipeline
// no dependencies
package pn3_pkg;

  localparam int unsigned FRAC_W = 16;

  typedef logic [7:0] cell_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [FRAC_W:0] fade_t;
  typedef logic signed [FRAC_W+1:0] ofs_t;
  typedef logic signed [FRAC_W+3:0] dot_t;
  typedef logic signed [FRAC_W+4:0] lerp_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // gradient select on the low four hash bits
  function automatic dot_t grad_dot(input logic [3:0] h, input ofs_t x, input ofs_t y,
                                    input ofs_t z);
    dot_t u;
    dot_t v;
    u = (h < 4'd8) ? dot_t'(x) : dot_t'(y);
    if (h < 4'd4) v = dot_t'(y);
    else if (h == 4'd12 || h == 4'd14) v = dot_t'(x);
    else v = dot_t'(z);
    grad_dot = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

// ----- src/pn3_lerp.sv -----
// one registered linear blend a + floor(w*(b-a)/65536)
// depends on pn3_pkg
module pn3_lerp (
  input  logic           clk,
  input  logic           en,
  input  pn3_pkg::lerp_t a,
  input  pn3_pkg::lerp_t b,
  input  pn3_pkg::fade_t w,
  output pn3_pkg::lerp_t y
);
  import pn3_pkg::*;

  logic signed [FRAC_W+5:0] diff;
  logic signed [2*FRAC_W+7:0] prod;
  lerp_t y_r;

  assign diff = (FRAC_W+6)'(b) - (FRAC_W+6)'(a);
  assign prod = diff * $signed({1'b0, w});

  // arithmetic shift floors toward minus infinity; result is a convex mix
  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= lerp_t'((2*FRAC_W+8)'(a) + (prod >>> FRAC_W));
    end
  end

  assign y = y_r;
endmodule

// ----- src/perlin_noise_3d.sv -----
// 3d improved gradient noise, one point per cycle
// out_valid follows start through the valid shift register, throughput one point per clock
// stages: split/square, cube/perm a,b, fade/second hash, corner hashes, dots, three lerp levels
// busy is never raised; rst_n (synchronous) clears the valid pipeline only
// depends on pn3_pkg and pn3_lerp
module perlin_noise_3d #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic               out_valid,
  output logic signed [15:0] out_noise_value
);
  import pn3_pkg::*;

  localparam int DN = (COORD_FRAC_BITS > 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int UP = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;

  logic [7:0] vld_r;
  assign busy = 1'b0;

  function automatic frac_t get_frac(input logic [31:0] r);
    logic [31:0] f;
    f = r & ((32'd1 << COORD_FRAC_BITS) - 32'd1);
    get_frac = frac_t'((f >> DN) << UP);
  endfunction

  function automatic cell_t get_cell(input logic [31:0] r);
    get_cell = cell_t'(r >> COORD_FRAC_BITS);
  endfunction

  // stage 1: split and square
  cell_t cx1_r, cy1_r, cz1_r;
  frac_t f1_r [3];
  logic [FRAC_W-1:0] t2_1_r [3];
  always_ff @(posedge clk) begin
    cx1_r <= get_cell(in_coord_x);
    cy1_r <= get_cell(in_coord_y);
    cz1_r <= get_cell(in_coord_z);
    for (int i = 0; i < 3; i++) begin
      logic [FRAC_W-1:0] f;
      f = (i == 0) ? get_frac(in_coord_x) : (i == 1) ? get_frac(in_coord_y)
        : get_frac(in_coord_z);
      f1_r[i] <= f;
      t2_1_r[i] <= FRAC_W'(({16'd0, f} * {16'd0, f}) >> FRAC_W);
    end
  end

  // stage 2: cube, polynomial, first hash level
  frac_t f2_r [3];
  logic [FRAC_W-1:0] t3_2_r [3];
  logic [19:0] p2_r [3];
  cell_t cy2_r, cz2_r, pa2_r, pb2_r;
  always_ff @(posedge clk) begin
    cy2_r <= cy1_r;
    cz2_r <= cz1_r;
    pa2_r <= PERM_ROM[cx1_r];
    pb2_r <= PERM_ROM[cell_t'(cx1_r + 8'd1)];
    for (int i = 0; i < 3; i++) begin
      f2_r[i] <= f1_r[i];
      t3_2_r[i] <= FRAC_W'(({16'd0, t2_1_r[i]} * {16'd0, f1_r[i]}) >> FRAC_W);
      p2_r[i] <= 20'd6 * 20'(t2_1_r[i]) + 20'd655360 - 20'd15 * 20'(f1_r[i]);
    end
  end

  // stage 3: fade and second hash level
  frac_t f3_r [3];
  fade_t fd3_r [3];
  cell_t cz3_r;
  cell_t h3_r [4];
  always_ff @(posedge clk) begin
    cell_t a, b;
    a = pa2_r + cy2_r;
    b = pb2_r + cy2_r;
    cz3_r <= cz2_r;
    h3_r[0] <= PERM_ROM[a];
    h3_r[1] <= PERM_ROM[cell_t'(a + 8'd1)];
    h3_r[2] <= PERM_ROM[b];
    h3_r[3] <= PERM_ROM[cell_t'(b + 8'd1)];
    for (int i = 0; i < 3; i++) begin
      f3_r[i] <= f2_r[i];
      fd3_r[i] <= fade_t'(({20'd0, t3_2_r[i]} * {16'd0, p2_r[i]}) >> FRAC_W);
    end
  end

  // stage 4: corner hashes; index bit2 = z, bit1 = y (ab/bb), bit0 = x (b*)
  frac_t f4_r [3];
  fade_t fd4_r [3];
  logic [3:0] g4_r [8];
  always_ff @(posedge clk) begin
    cell_t aa, ab, ba, bb;
    aa = h3_r[0] + cz3_r;
    ab = h3_r[1] + cz3_r;
    ba = h3_r[2] + cz3_r;
    bb = h3_r[3] + cz3_r;
    g4_r[0] <= PERM_ROM[aa][3:0];
    g4_r[1] <= PERM_ROM[ba][3:0];
    g4_r[2] <= PERM_ROM[ab][3:0];
    g4_r[3] <= PERM_ROM[bb][3:0];
    g4_r[4] <= PERM_ROM[cell_t'(aa + 8'd1)][3:0];
    g4_r[5] <= PERM_ROM[cell_t'(ba + 8'd1)][3:0];
    g4_r[6] <= PERM_ROM[cell_t'(ab + 8'd1)][3:0];
    g4_r[7] <= PERM_ROM[cell_t'(bb + 8'd1)][3:0];
    for (int i = 0; i < 3; i++) begin
      f4_r[i] <= f3_r[i];
      fd4_r[i] <= fd3_r[i];
    end
  end

  // stage 5: gradient dots
  lerp_t d5_r [8];
  fade_t fd5_r [3];
  always_ff @(posedge clk) begin
    ofs_t o0 [3];
    ofs_t o1 [3];
    for (int i = 0; i < 3; i++) begin
      o0[i] = ofs_t'({2'b00, f4_r[i]});
      o1[i] = o0[i] - ofs_t'(18'sd65536);
      fd5_r[i] <= fd4_r[i];
    end
    for (int c = 0; c < 8; c++) begin
      d5_r[c] <= lerp_t'(grad_dot(g4_r[c], c[0] ? o1[0] : o0[0], c[1] ? o1[1] : o0[1],
                                  c[2] ? o1[2] : o0[2]));
    end
  end

  // lerp levels, each one register stage
  lerp_t lx [4];
  lerp_t ly [2];
  lerp_t lz;
  fade_t fd6_r [2];
  fade_t fd7_r;
  always_ff @(posedge clk) begin
    fd6_r[0] <= fd5_r[1];
    fd6_r[1] <= fd5_r[2];
    fd7_r <= fd6_r[1];
  end

  for (genvar k = 0; k < 4; k++) begin : g_lx
    pn3_lerp u_lx (.clk(clk), .en(1'b1), .a(d5_r[2*k]), .b(d5_r[2*k+1]), .w(fd5_r[0]),
                   .y(lx[k]));
  end
  pn3_lerp u_ly0 (.clk(clk), .en(1'b1), .a(lx[0]), .b(lx[1]), .w(fd6_r[0]), .y(ly[0]));
  pn3_lerp u_ly1 (.clk(clk), .en(1'b1), .a(lx[2]), .b(lx[3]), .w(fd6_r[0]), .y(ly[1]));
  pn3_lerp u_lz (.clk(clk), .en(1'b1), .a(ly[0]), .b(ly[1]), .w(fd7_r), .y(lz));

  // output: floor divide by four and clamp
  lerp_t q;
  assign q = lz >>> 2;
  always_comb begin
    if (q > lerp_t'(32767)) out_noise_value = 16'sh7fff;
    else if (q < -lerp_t'(32768)) out_noise_value = -16'sh8000;
    else out_noise_value = q[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[6:0], start};
  end
  assign out_valid = vld_r[7];

`ifndef SYNTH
  a_never_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##7 out_valid) else $error("transfer lost in pipeline");
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[6])) else $error("result without transfer");
`endif
endmodule

// ----- dv/testbench.sv -----
// testbench for perlin_noise_3d: directed and random points against an in-bench noise predictor
// depends on pn3_pkg (permutation table) and the perlin_noise_3d top level
module testbench;
  import pn3_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 8;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic signed [31:0] in_coord_z;
  logic out_valid;
  logic signed [15:0] out_noise_value;

  logic signed [15:0] noise_q[$];
  int errors;
  longint cycles;
  int send_idle_pct;

  perlin_noise_3d #(.COORD_FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_noise_value(out_noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic void split(input logic [31:0] raw, output logic [7:0] cell_idx,
                                output longint fr);
    logic [31:0] f;
    f = raw & ((32'd1 << FRAC_BITS) - 1);
    cell_idx = 8'(raw >> FRAC_BITS);
    if (FRAC_BITS > 16) fr = longint'(f >> (FRAC_BITS - 16));
    else fr = longint'(f << (16 - FRAC_BITS));
  endfunction

  function automatic longint fade(input longint t);
    longint t2;
    longint t3;
    longint p;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    p = 6 * t2 + 10 * 65536 - 15 * t;
    return (t3 * p) >> 16;
  endfunction

  function automatic longint gradient(input logic [7:0] hv, input longint x, input longint y,
                                      input longint z);
    logic [3:0] h;
    longint u;
    longint v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint mix(input longint a, input longint b, input longint w);
    return a + floor_div(w * (b - a), 16);
  endfunction

  function automatic logic [7:0] perm(input logic [7:0] i);
    return PERM_ROM[i];
  endfunction

  function automatic logic signed [15:0] noise_at(input logic [31:0] px, input logic [31:0] py,
                                                 input logic [31:0] pz);
    logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    longint fx, fy, fz, u, v, w, x1, y1, z1, n00, n10, n01, n11, r;
    split(px, cx, fx);
    split(py, cy, fy);
    split(pz, cz, fz);
    u = fade(fx);
    v = fade(fy);
    w = fade(fz);
    a = perm(cx) + cy;
    aa = perm(a) + cz;
    ab = perm(a + 8'd1) + cz;
    b = perm(cx + 8'd1) + cy;
    ba = perm(b) + cz;
    bb = perm(b + 8'd1) + cz;
    x1 = fx - 65536;
    y1 = fy - 65536;
    z1 = fz - 65536;
    n00 = mix(gradient(perm(aa), fx, fy, fz), gradient(perm(ba), x1, fy, fz), u);
    n10 = mix(gradient(perm(ab), fx, y1, fz), gradient(perm(bb), x1, y1, fz), u);
    n01 = mix(gradient(perm(aa + 8'd1), fx, fy, z1), gradient(perm(ba + 8'd1), x1, fy, z1), u);
    n11 = mix(gradient(perm(ab + 8'd1), fx, y1, z1), gradient(perm(bb + 8'd1), x1, y1, z1), u);
    r = floor_div(mix(mix(n00, n10, v), mix(n01, n11, v), w), 2);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // send one point; start stays high across back-to-back transfers
  task automatic send_point(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_coord_x <= px;
    in_coord_y <= py;
    in_coord_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    noise_q.push_back(noise_at(px, py, pz));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (noise_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2048)) - 1024) << 12;
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return {8'($urandom()), 8'($urandom()), 16'($urandom())};
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges[8];
    edges = '{32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff,
              32'h00008000, 32'hffff0000, 32'h00ff0001, 32'h0000ffff};
    for (int i = 0; i < 8; i++) send_point(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
    for (int i = 0; i < 8; i++) send_point(edges[i], edges[i], edges[i]);
    // lattice walk over cell wrap and negative cells
    for (int i = 0; i < 8; i++)
      send_point(32'(i - 4) <<< 16 | 32'h4000, 32'h00ff8000 + (i << 16), 32'hff00c000);
  endtask

  task automatic test_random(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord());
      if (i == count / 2) drain();
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (noise_q.size() == 0) begin
        $error("unexpected transfer: noise_value %0d", out_noise_value);
        errors++;
      end else begin
        if (out_noise_value !== noise_q[0]) begin
          $error("noise_value expected %0d actual %0d", noise_q[0], out_noise_value);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(600, 8);
    test_random(600, 84);
    test_random(700, 0);
    drain();
    if (errors == 0 && noise_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
src/pn3_pkg.sv
src/pn3_lerp.sv
src/perlin_noise_3d.sv
dv/testbench.sv
